// ===== hdl/s2c_pkg.sv =====
package s2c_pkg;

    localparam int STAMP_W = 32;
    localparam int REM_W   = 27;
    localparam int QUO_W   = 9;
    localparam int STEPS_W = 4;
    localparam int DOY_W   = 9;
    localparam int SOD_W   = 17;

    localparam logic [REM_W-1:0] SECS_4Y    = REM_W'(1461 * 24 * 60 * 60);
    localparam logic [REM_W-1:0] SECS_LEAPY = REM_W'(366 * 24 * 60 * 60);
    localparam logic [REM_W-1:0] SECS_YEAR  = REM_W'(365 * 24 * 60 * 60);
    localparam logic [REM_W-1:0] SECS_DAY   = REM_W'(24 * 60 * 60);
    localparam logic [REM_W-1:0] SECS_HOUR  = REM_W'(60 * 60);
    localparam logic [REM_W-1:0] SECS_MIN   = REM_W'(60);

    localparam logic [STEPS_W-1:0] STEPS_4Y   = STEPS_W'(6);
    localparam logic [STEPS_W-1:0] STEPS_DAY  = STEPS_W'(9);
    localparam logic [STEPS_W-1:0] STEPS_HOUR = STEPS_W'(5);
    localparam logic [STEPS_W-1:0] STEPS_MIN  = STEPS_W'(6);

    localparam logic [3:0] MONTH_JAN = 4'd1;
    localparam logic [3:0] MONTH_FEB = 4'd2;
    localparam logic [3:0] MONTH_DEC = 4'd12;

    typedef struct packed {
        logic               start;
        logic [STEPS_W-1:0] steps;
        logic [REM_W-1:0]   divisor;
        logic [REM_W-1:0]   rem_init;
        logic [STAMP_W-1:0] bits;
    } div_ctl_t;

    typedef struct packed {
        logic             done;
        logic [QUO_W-1:0] quo;
        logic [REM_W-1:0] rem;
    } div_sts_t;

    function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
        logic [4:0] days;
        unique case (month)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: days = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                      days = 5'd30;
            MONTH_FEB:                                    days = leap ? 5'd29 : 5'd28;
            default:                                      days = 5'd31;
        endcase
        return days;
    endfunction

endpackage

// ===== hdl/seconds_to_calendar_unit.sv =====
// Each stamp passes through one shared serial divider (one quotient bit per
// cycle) and the year and month subtract loops. A new stamp is taken only
// once the previous one has been handed to the output register.
// Reset (aresetn low, synchronous) returns the unit to idle with no result valid.
module seconds_to_calendar_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // stamp[31:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // year[7:0], month[11:8], day[16:12], hour[21:17],
                                   // minute[27:22], second[33:28], zero[39:34]
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV4Y,
        ST_YEARS,
        ST_DIVDAY,
        ST_MONTHS,
        ST_DIVHR,
        ST_DIVMIN,
        ST_OUT
    } state_t;

    state_t                    state_reg;
    s2c_pkg::div_ctl_t         div_ctl;
    s2c_pkg::div_sts_t         div_sts;

    logic [5:0]                cycle4_reg;
    logic [1:0]                yoff_reg;
    logic [s2c_pkg::REM_W-1:0] rest_reg;
    logic [s2c_pkg::DOY_W-1:0] doy_reg;
    logic [s2c_pkg::SOD_W-1:0] sod_reg;
    logic [3:0]                month_reg;
    logic [4:0]                hour_reg;
    logic [5:0]                minute_reg;
    logic [5:0]                second_reg;

    logic                      m_tvalid_reg;
    logic [7:0]                year_out_reg;
    logic [3:0]                month_out_reg;
    logic [4:0]                day_out_reg;
    logic [4:0]                hour_out_reg;
    logic [5:0]                minute_out_reg;
    logic [5:0]                second_out_reg;

    logic                      leap;
    logic [s2c_pkg::REM_W-1:0] year_len;
    logic                      year_take;
    logic [s2c_pkg::DOY_W-1:0] month_len;
    logic                      month_take;
    logic                      out_load;

    assign leap       = yoff_reg == 2'd0;
    assign year_len   = leap ? s2c_pkg::SECS_LEAPY : s2c_pkg::SECS_YEAR;
    assign year_take  = rest_reg >= year_len;
    assign month_len  = {4'b0, s2c_pkg::month_days(month_reg, leap)};
    assign month_take = (month_reg != s2c_pkg::MONTH_DEC) && (doy_reg >= month_len);
    assign out_load   = (state_reg == ST_OUT) && (!m_tvalid_reg || m_tready);

    always_comb begin
        div_ctl = '0;
        unique case (state_reg)
            ST_IDLE: begin
                div_ctl.start    = s_tvalid;
                div_ctl.steps    = s2c_pkg::STEPS_4Y;
                div_ctl.divisor  = s2c_pkg::SECS_4Y;
                div_ctl.rem_init = {1'b0, s_tdata[31:6]};
                div_ctl.bits     = {s_tdata[5:0], 26'b0};
            end
            ST_YEARS: begin
                div_ctl.start    = !year_take;
                div_ctl.steps    = s2c_pkg::STEPS_DAY;
                div_ctl.divisor  = s2c_pkg::SECS_DAY;
                div_ctl.rem_init = {11'b0, rest_reg[24:9]};
                div_ctl.bits     = {rest_reg[8:0], 23'b0};
            end
            ST_MONTHS: begin
                div_ctl.start    = !month_take;
                div_ctl.steps    = s2c_pkg::STEPS_HOUR;
                div_ctl.divisor  = s2c_pkg::SECS_HOUR;
                div_ctl.rem_init = {15'b0, sod_reg[16:5]};
                div_ctl.bits     = {sod_reg[4:0], 27'b0};
            end
            ST_DIVHR: begin
                div_ctl.start    = div_sts.done;
                div_ctl.steps    = s2c_pkg::STEPS_MIN;
                div_ctl.divisor  = s2c_pkg::SECS_MIN;
                div_ctl.rem_init = {21'b0, div_sts.rem[11:6]};
                div_ctl.bits     = {div_sts.rem[5:0], 26'b0};
            end
            default: begin
                div_ctl = '0;
            end
        endcase
    end

    s2c_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (div_ctl),
        .sts     (div_sts)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        state_reg <= ST_DIV4Y;
                    end
                end
                ST_DIV4Y: begin
                    if (div_sts.done) begin
                        cycle4_reg <= div_sts.quo[5:0];
                        rest_reg   <= div_sts.rem;
                        yoff_reg   <= 2'd0;
                        state_reg  <= ST_YEARS;
                    end
                end
                ST_YEARS: begin
                    if (year_take) begin
                        rest_reg <= rest_reg - year_len;
                        yoff_reg <= yoff_reg + 2'd1;
                    end else begin
                        state_reg <= ST_DIVDAY;
                    end
                end
                ST_DIVDAY: begin
                    if (div_sts.done) begin
                        doy_reg   <= div_sts.quo;
                        sod_reg   <= div_sts.rem[s2c_pkg::SOD_W-1:0];
                        month_reg <= s2c_pkg::MONTH_JAN;
                        state_reg <= ST_MONTHS;
                    end
                end
                ST_MONTHS: begin
                    if (month_take) begin
                        doy_reg   <= doy_reg - month_len;
                        month_reg <= month_reg + 4'd1;
                    end else begin
                        state_reg <= ST_DIVHR;
                    end
                end
                ST_DIVHR: begin
                    if (div_sts.done) begin
                        hour_reg  <= div_sts.quo[4:0];
                        state_reg <= ST_DIVMIN;
                    end
                end
                ST_DIVMIN: begin
                    if (div_sts.done) begin
                        minute_reg <= div_sts.quo[5:0];
                        second_reg <= div_sts.rem[5:0];
                        state_reg  <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (out_load) begin
                        year_out_reg   <= {cycle4_reg, yoff_reg};
                        month_out_reg  <= month_reg;
                        day_out_reg    <= doy_reg[4:0] + 5'd1;
                        hour_out_reg   <= hour_reg;
                        minute_out_reg <= minute_reg;
                        second_out_reg <= second_reg;
                        state_reg      <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready = state_reg == ST_IDLE;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'b0, second_out_reg, minute_out_reg, hour_out_reg,
                       day_out_reg, month_out_reg, year_out_reg};

endmodule

// ===== hdl/s2c_div.sv =====
module s2c_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  s2c_pkg::div_ctl_t ctl,
    output s2c_pkg::div_sts_t sts
);

    logic [s2c_pkg::REM_W-1:0]   rem_reg;
    logic [s2c_pkg::REM_W-1:0]   rem_next;
    logic [s2c_pkg::REM_W-1:0]   divisor_reg;
    logic [s2c_pkg::STAMP_W-1:0] bits_reg;
    logic [s2c_pkg::QUO_W-1:0]   quo_reg;
    logic [s2c_pkg::STEPS_W-1:0] cnt_reg;
    logic                        busy_reg;
    logic                        done_reg;
    logic [s2c_pkg::REM_W:0]     shifted;
    logic [s2c_pkg::REM_W:0]     diff;
    logic                        fits;

    assign shifted  = {rem_reg, bits_reg[s2c_pkg::STAMP_W-1]};
    assign fits     = shifted >= {1'b0, divisor_reg};
    assign diff     = shifted - {1'b0, divisor_reg};
    assign rem_next = fits ? diff[s2c_pkg::REM_W-1:0] : shifted[s2c_pkg::REM_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (ctl.start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == s2c_pkg::STEPS_W'(1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.start) begin
            rem_reg     <= ctl.rem_init;
            bits_reg    <= ctl.bits;
            divisor_reg <= ctl.divisor;
            quo_reg     <= '0;
            cnt_reg     <= ctl.steps;
        end else if (busy_reg) begin
            rem_reg  <= rem_next;
            bits_reg <= {bits_reg[s2c_pkg::STAMP_W-2:0], 1'b0};
            quo_reg  <= {quo_reg[s2c_pkg::QUO_W-2:0], fits};
            cnt_reg  <= cnt_reg - s2c_pkg::STEPS_W'(1);
        end
    end

    assign sts.done = done_reg;
    assign sts.quo  = quo_reg;
    assign sts.rem  = rem_reg;

endmodule
